// File: rtl/core/ut2a_pkg.sv
// Shared types, constants and symbol lookup for the typography-to-ASCII unit.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none
package ut2a_pkg;

   localparam int BLANK_MAX = 16;
   localparam int BLANK_CW = $clog2(BLANK_MAX + 1);
   localparam int BLANK_IW = $clog2(BLANK_MAX);
   localparam int QUEUE_DEPTH = 32;
   localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

   localparam int GRP_DASH = 0;
   localparam int GRP_QUOTE = 1;
   localparam int GRP_ELLIP = 2;
   localparam int GRP_SPACE = 3;
   localparam int GRP_BULLET = 4;
   localparam int GRP_ARROW = 5;
   localparam int GRP_BOX = 6;
   localparam int GRP_MATH = 7;
   localparam int GRP_LIG = 8;
   localparam int GRP_MARK = 9;
   localparam int GRP_LEGAL = 10;
   localparam int GRP_FULL = 11;
   localparam int GRP_UPDOWN = 12;
   localparam int GRP_BLOCK = 13;
   localparam int GRP_SUPER = 14;

   localparam logic [1:0] CSR_GROUP_ENABLE = 2'd0;
   localparam logic [1:0] CSR_BYTE_BEFORE = 2'd1;
   localparam logic [1:0] CSR_BYTE_AFTER = 2'd2;

   localparam logic [14:0] GROUP_ENABLE_RST = 15'd511;
   localparam logic [7:0] EDGE_BYTE_RST = 8'h0A;
   localparam logic [20:0] CP_EM_DASH = 21'h02014;
   localparam logic [20:0] CP_FULL_LO = 21'h0FF01;
   localparam logic [20:0] CP_FULL_HI = 21'h0FF5E;
   localparam logic [20:0] CP_FULL_OFS = 21'h0FEE0;

   typedef enum logic [4:0] {
      OP_NONE, OP_LATCH, OP_APPEND, OP_START, OP_TK_CP_B, OP_TK_RAW_B, OP_TK_SEQ,
      OP_TK_PEND, OP_RUN_LEAD, OP_RUN_DASH, OP_RUN_TAIL, OP_BLANK_PUSH, OP_DASH_START,
      OP_FLUSH_ONE, OP_LOAD_TEXT, OP_EMIT_TEXT, OP_MARK, OP_RD, OP_SHOW, OP_POP, OP_CLEAR
   } op_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_PRE, ST_FLUSH, ST_MAIN, ST_FIN, ST_TK, ST_RUN_LEAD, ST_RUN_DASH,
      ST_RUN_TAIL, ST_CLASS, ST_TK_BL, ST_TEXT, ST_CHECK, ST_EOR_BL, ST_MARK,
      ST_DRAIN, ST_SHOW, ST_WAIT
   } state_type;

   typedef struct packed {
      op_type op;
      logic   use_after;
   } cmd_type;

   typedef struct packed {
      logic dcnt_nz;
      logic is_cont;
      logic b_lt80;
      logic b_lead;
      logic seq_full;
      logic seq_valid;
      logic in_run;
      logic tk_blank;
      logic tk_emdash;
      logic dash_on;
      logic blank_nz;
      logic text_more;
      logic eor;
      logic drain_more;
      logic rsp_done;
   } sts_type;

   typedef struct packed {
      logic        hit;
      logic [2:0]  len;
      logic [31:0] txt;
   } map_res_type;

   function automatic logic is_edge(input logic [7:0] b);
      return b == 8'h0A || b == 8'h0D || b == 8'h20 || b == 8'h09;
   endfunction

   function automatic logic [2:0] seq_len(input logic [7:0] lead);
      return lead < 8'hE0 ? 3'd2 : (lead < 8'hF0 ? 3'd3 : 3'd4);
   endfunction

   function automatic map_res_type sym(input logic on, input logic [2:0] len,
                                       input logic [31:0] s);
      map_res_type r;
      r.hit = on;
      r.len = len;
      r.txt = s;
      return r;
   endfunction

   function automatic logic [7:0] box_text(input logic [6:0] off);
      logic [7:0] c;
      c = "+";
      if (off <= 7'h0B) c = off[1] ? "|" : "-";
      else if (off >= 7'h4C && off <= 7'h4F) c = (off <= 7'h4D) ? "-" : "|";
      else if (off == 7'h50) c = "-";
      else if (off == 7'h51) c = "|";
      else if (off == 7'h71) c = "/";
      else if (off == 7'h72) c = "\\";
      else if (off == 7'h73) c = "X";
      else if (off >= 7'h74) c = off[0] ? "|" : "-";
      return c;
   endfunction

   // Text is right-justified: the first character sits in byte len-1.
   function automatic map_res_type map_sym(input logic [20:0] cp, input logic [14:0] gen);
      map_res_type r;
      r = '0;
      case (cp) inside
         [21'h2500:21'h257F]: r = sym(gen[GRP_BOX], 3'd1, {24'd0, box_text(cp[6:0])});
         [21'h2580:21'h259F]: r = sym(gen[GRP_BLOCK], 3'd1, "#");
         [21'h2000:21'h200A]: r = sym(gen[GRP_SPACE], 3'd1, " ");
         [21'h200B:21'h200F], [21'h202A:21'h202E], [21'h2066:21'h2069],
         21'h00AD, 21'h2060, 21'hFEFF: r = sym(gen[GRP_SPACE], 3'd0, 32'd0);
         [21'h25B6:21'h25BB]: r = sym(gen[GRP_ARROW], 3'd1, ">");
         [21'h25C0:21'h25C5]: r = sym(gen[GRP_ARROW], 3'd1, "<");
         [21'h25B2:21'h25B5]: r = sym(gen[GRP_ARROW], 3'd1, "^");
         [21'h25BC:21'h25BF]: r = sym(gen[GRP_ARROW], 3'd1, "v");
         21'h2011, 21'h2012, 21'h2013, 21'h2015, 21'h2212, 21'hFF0D:
            r = sym(gen[GRP_DASH], 3'd1, "-");
         21'h2018, 21'h2019, 21'h201A, 21'h201B, 21'h2039, 21'h203A, 21'h02BC, 21'h2032:
            r = sym(gen[GRP_QUOTE], 3'd1, "'");
         21'h201C, 21'h201D, 21'h201E, 21'h201F, 21'h00AB, 21'h00BB, 21'h2033:
            r = sym(gen[GRP_QUOTE], 3'd1, "\"");
         21'h2026: r = sym(gen[GRP_ELLIP], 3'd3, "...");
         21'h00A0, 21'h202F, 21'h205F: r = sym(gen[GRP_SPACE], 3'd1, " ");
         21'h2022, 21'h2023, 21'h2043, 21'h25E6, 21'h25AA, 21'h25CF, 21'h00B7:
            r = sym(gen[GRP_BULLET], 3'd1, "-");
         21'h2192, 21'h27F6: r = sym(gen[GRP_ARROW], 3'd2, "->");
         21'h2190, 21'h27F5: r = sym(gen[GRP_ARROW], 3'd2, "<-");
         21'h2194, 21'h27F7: r = sym(gen[GRP_ARROW], 3'd3, "<->");
         21'h21D2, 21'h27F9: r = sym(gen[GRP_ARROW], 3'd2, "=>");
         21'h21D0, 21'h27F8: r = sym(gen[GRP_ARROW], 3'd2, "<=");
         21'h21D4, 21'h27FA: r = sym(gen[GRP_ARROW], 3'd3, "<=>");
         21'h2264: r = sym(gen[GRP_MATH], 3'd2, "<=");
         21'h2265: r = sym(gen[GRP_MATH], 3'd2, ">=");
         21'h2260: r = sym(gen[GRP_MATH], 3'd2, "!=");
         21'h2248: r = sym(gen[GRP_MATH], 3'd1, "~");
         21'h00D7: r = sym(gen[GRP_MATH], 3'd1, "x");
         21'h00F7, 21'h2044: r = sym(gen[GRP_MATH], 3'd1, "/");
         21'h00B1: r = sym(gen[GRP_MATH], 3'd3, "+/-");
         21'h2219, 21'h22C5: r = sym(gen[GRP_MATH], 3'd1, "*");
         21'h00BC: r = sym(gen[GRP_MATH], 3'd3, "1/4");
         21'h00BD: r = sym(gen[GRP_MATH], 3'd3, "1/2");
         21'h00BE: r = sym(gen[GRP_MATH], 3'd3, "3/4");
         21'h2150: r = sym(gen[GRP_MATH], 3'd3, "1/7");
         21'h2151: r = sym(gen[GRP_MATH], 3'd3, "1/9");
         21'h2152: r = sym(gen[GRP_MATH], 3'd4, "1/10");
         21'h2153: r = sym(gen[GRP_MATH], 3'd3, "1/3");
         21'h2154: r = sym(gen[GRP_MATH], 3'd3, "2/3");
         21'h2155: r = sym(gen[GRP_MATH], 3'd3, "1/5");
         21'h2156: r = sym(gen[GRP_MATH], 3'd3, "2/5");
         21'h2157: r = sym(gen[GRP_MATH], 3'd3, "3/5");
         21'h2158: r = sym(gen[GRP_MATH], 3'd3, "4/5");
         21'h2159: r = sym(gen[GRP_MATH], 3'd3, "1/6");
         21'h215A: r = sym(gen[GRP_MATH], 3'd3, "5/6");
         21'h215B: r = sym(gen[GRP_MATH], 3'd3, "1/8");
         21'h215C: r = sym(gen[GRP_MATH], 3'd3, "3/8");
         21'h215D: r = sym(gen[GRP_MATH], 3'd3, "5/8");
         21'h215E: r = sym(gen[GRP_MATH], 3'd3, "7/8");
         21'h2713, 21'h2714, 21'h2705: r = sym(gen[GRP_MARK], 3'd3, "[x]");
         21'h2717, 21'h2718, 21'h274C: r = sym(gen[GRP_MARK], 3'd1, "x");
         21'h2605, 21'h2606: r = sym(gen[GRP_MARK], 3'd1, "*");
         21'h2122: r = sym(gen[GRP_LEGAL], 3'd4, "(TM)");
         21'h2120: r = sym(gen[GRP_LEGAL], 3'd4, "(SM)");
         21'h00A9: r = sym(gen[GRP_LEGAL], 3'd3, "(c)");
         21'h00AE: r = sym(gen[GRP_LEGAL], 3'd3, "(R)");
         21'h3000: r = sym(gen[GRP_FULL], 3'd1, " ");
         21'h2191, 21'h21D1: r = sym(gen[GRP_UPDOWN], 3'd1, "^");
         21'h2193, 21'h21D3: r = sym(gen[GRP_UPDOWN], 3'd1, "v");
         21'h00B9: r = sym(gen[GRP_SUPER], 3'd1, "1");
         21'h00B2: r = sym(gen[GRP_SUPER], 3'd1, "2");
         21'h00B3: r = sym(gen[GRP_SUPER], 3'd1, "3");
         21'h2070: r = sym(gen[GRP_SUPER], 3'd1, "0");
         21'h2074: r = sym(gen[GRP_SUPER], 3'd1, "4");
         21'h2075: r = sym(gen[GRP_SUPER], 3'd1, "5");
         21'h2076: r = sym(gen[GRP_SUPER], 3'd1, "6");
         21'h2077: r = sym(gen[GRP_SUPER], 3'd1, "7");
         21'h2078: r = sym(gen[GRP_SUPER], 3'd1, "8");
         21'h2079: r = sym(gen[GRP_SUPER], 3'd1, "9");
         21'hFB00: r = sym(gen[GRP_LIG], 3'd2, "ff");
         21'hFB01: r = sym(gen[GRP_LIG], 3'd2, "fi");
         21'hFB02: r = sym(gen[GRP_LIG], 3'd2, "fl");
         21'hFB03: r = sym(gen[GRP_LIG], 3'd3, "ffi");
         21'hFB04: r = sym(gen[GRP_LIG], 3'd3, "ffl");
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/ut2a_ctrl.sv
// Controller state machine of the typography-to-ASCII unit.
// Sequences decode, token handling, flushing and result drain; uses ut2a_pkg.
`default_nettype none
module ut2a_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_tvalid,
   output logic                 req_tready,
   input  wire ut2a_pkg::sts_type sts,
   output ut2a_pkg::cmd_type    cmd
);
   ut2a_pkg::state_type state_ff, state_in;
   logic flush_ret_ff, flush_ret_in;   // 0: main decode, 1: end check
   logic tok_flush_ff, tok_flush_in;   // token came from a raw flush
   logic tail_ff, tail_in;             // end-of-range tail in progress
   ut2a_pkg::state_type tok_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ut2a_pkg::ST_IDLE;
         flush_ret_ff <= 1'b0;
         tok_flush_ff <= 1'b0;
         tail_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         flush_ret_ff <= flush_ret_in;
         tok_flush_ff <= tok_flush_in;
         tail_ff <= tail_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      flush_ret_in = flush_ret_ff;
      tok_flush_in = tok_flush_ff;
      tail_in = tail_ff;
      cmd.op = ut2a_pkg::OP_NONE;
      cmd.use_after = tail_ff;
      req_tready = 1'b0;
      tok_done = tok_flush_ff ? ut2a_pkg::ST_FLUSH : ut2a_pkg::ST_CHECK;
      case (state_ff)
         ut2a_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op = ut2a_pkg::OP_LATCH;
               tail_in = 1'b0;
               state_in = ut2a_pkg::ST_PRE;
            end
         end
         ut2a_pkg::ST_PRE: begin
            if (sts.dcnt_nz && !sts.is_cont) begin
               flush_ret_in = 1'b0;
               state_in = ut2a_pkg::ST_FLUSH;
            end else begin
               state_in = ut2a_pkg::ST_MAIN;
            end
         end
         ut2a_pkg::ST_FLUSH: begin
            if (sts.dcnt_nz) begin
               cmd.op = ut2a_pkg::OP_TK_PEND;
               tok_flush_in = 1'b1;
               state_in = ut2a_pkg::ST_TK;
            end else begin
               state_in = flush_ret_ff ? ut2a_pkg::ST_CHECK : ut2a_pkg::ST_MAIN;
            end
         end
         ut2a_pkg::ST_MAIN: begin
            tok_flush_in = 1'b0;
            if (sts.dcnt_nz) begin
               cmd.op = ut2a_pkg::OP_APPEND;
               state_in = ut2a_pkg::ST_FIN;
            end else if (sts.b_lt80) begin
               cmd.op = ut2a_pkg::OP_TK_CP_B;
               state_in = ut2a_pkg::ST_TK;
            end else if (sts.b_lead) begin
               cmd.op = ut2a_pkg::OP_START;
               state_in = ut2a_pkg::ST_CHECK;
            end else begin
               cmd.op = ut2a_pkg::OP_TK_RAW_B;
               state_in = ut2a_pkg::ST_TK;
            end
         end
         ut2a_pkg::ST_FIN: begin
            if (!sts.seq_full) begin
               state_in = ut2a_pkg::ST_CHECK;
            end else if (sts.seq_valid) begin
               cmd.op = ut2a_pkg::OP_TK_SEQ;
               state_in = ut2a_pkg::ST_TK;
            end else begin
               flush_ret_in = 1'b1;
               state_in = ut2a_pkg::ST_FLUSH;
            end
         end
         ut2a_pkg::ST_TK: begin
            if (sts.in_run) begin
               if (sts.tk_blank || sts.tk_emdash) state_in = tok_done;
               else state_in = ut2a_pkg::ST_RUN_LEAD;
            end else begin
               state_in = ut2a_pkg::ST_CLASS;
            end
         end
         ut2a_pkg::ST_RUN_LEAD: begin
            cmd.op = ut2a_pkg::OP_RUN_LEAD;
            state_in = ut2a_pkg::ST_RUN_DASH;
         end
         ut2a_pkg::ST_RUN_DASH: begin
            cmd.op = ut2a_pkg::OP_RUN_DASH;
            state_in = ut2a_pkg::ST_RUN_TAIL;
         end
         ut2a_pkg::ST_RUN_TAIL: begin
            cmd.op = ut2a_pkg::OP_RUN_TAIL;
            state_in = tail_ff ? ut2a_pkg::ST_EOR_BL : ut2a_pkg::ST_CLASS;
         end
         ut2a_pkg::ST_CLASS: begin
            if (sts.tk_blank) begin
               cmd.op = ut2a_pkg::OP_BLANK_PUSH;
               state_in = tok_done;
            end else if (sts.tk_emdash && sts.dash_on) begin
               cmd.op = ut2a_pkg::OP_DASH_START;
               state_in = tok_done;
            end else begin
               state_in = ut2a_pkg::ST_TK_BL;
            end
         end
         ut2a_pkg::ST_TK_BL: begin
            if (sts.blank_nz) begin
               cmd.op = ut2a_pkg::OP_FLUSH_ONE;
            end else begin
               cmd.op = ut2a_pkg::OP_LOAD_TEXT;
               state_in = ut2a_pkg::ST_TEXT;
            end
         end
         ut2a_pkg::ST_TEXT: begin
            if (sts.text_more) cmd.op = ut2a_pkg::OP_EMIT_TEXT;
            else state_in = tok_done;
         end
         ut2a_pkg::ST_CHECK: begin
            if (!sts.eor) begin
               state_in = ut2a_pkg::ST_DRAIN;
            end else if (sts.dcnt_nz) begin
               flush_ret_in = 1'b1;
               tok_flush_in = 1'b1;
               state_in = ut2a_pkg::ST_FLUSH;
            end else begin
               tail_in = 1'b1;
               state_in = sts.in_run ? ut2a_pkg::ST_RUN_LEAD : ut2a_pkg::ST_EOR_BL;
            end
         end
         ut2a_pkg::ST_EOR_BL: begin
            if (sts.blank_nz) cmd.op = ut2a_pkg::OP_FLUSH_ONE;
            else state_in = ut2a_pkg::ST_MARK;
         end
         ut2a_pkg::ST_MARK: begin
            cmd.op = ut2a_pkg::OP_MARK;
            state_in = ut2a_pkg::ST_DRAIN;
         end
         ut2a_pkg::ST_DRAIN: begin
            if (sts.drain_more) begin
               cmd.op = ut2a_pkg::OP_RD;
               state_in = ut2a_pkg::ST_SHOW;
            end else begin
               cmd.op = ut2a_pkg::OP_CLEAR;
               state_in = ut2a_pkg::ST_IDLE;
            end
         end
         ut2a_pkg::ST_SHOW: begin
            cmd.op = ut2a_pkg::OP_SHOW;
            state_in = ut2a_pkg::ST_WAIT;
         end
         ut2a_pkg::ST_WAIT: begin
            if (sts.rsp_done) begin
               cmd.op = ut2a_pkg::OP_POP;
               state_in = ut2a_pkg::ST_DRAIN;
            end
         end
         default: state_in = ut2a_pkg::ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire

// File: rtl/core/ut2a_dpath.sv
// Datapath of the typography-to-ASCII unit: decoder, blank buffer, dash run,
// counters, result queue and output register. Uses ut2a_pkg.
`default_nettype none
module ut2a_dpath (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ut2a_pkg::cmd_type cmd,
   output ut2a_pkg::sts_type      sts,
   input  wire logic [7:0]        in_byte,
   input  wire logic              in_eor,
   input  wire logic              csr_we,
   input  wire logic [1:0]        csr_index,
   input  wire logic [14:0]       csr_data,
   input  wire logic              rsp_ready,
   output logic                   rsp_valid,
   output logic [7:0]             rsp_byte,
   output logic                   rsp_has,
   output logic                   rsp_last,
   output logic [15:0]            rsp_total
);
   localparam int BCW = ut2a_pkg::BLANK_CW;
   localparam int BIW = ut2a_pkg::BLANK_IW;
   localparam int QAW = ut2a_pkg::QUEUE_AW;
   localparam int QCW = ut2a_pkg::QUEUE_CW;

   logic [14:0] gen_ff, gen_in;
   logic [7:0]  bbr_ff, bbr_in, bar_ff, bar_in;
   logic [7:0]  byte_ff, byte_in;
   logic        eor_ff, eor_in;
   logic [31:0] dbytes_ff, dbytes_in;
   logic [2:0]  dcnt_ff, dcnt_in;
   logic        tk_is_cp_ff, tk_is_cp_in;
   logic [20:0] tk_cp_ff, tk_cp_in;
   logic [31:0] tk_raw_ff, tk_raw_in;
   logic [2:0]  tk_n_ff, tk_n_in;
   logic [ut2a_pkg::BLANK_MAX-1:0] flags_ff, flags_in;
   logic [BCW-1:0] bcnt_ff, bcnt_in;
   logic [7:0]  bbb_ff, bbb_in;
   logic        run_ff, run_in, lead_ff, lead_in;
   logic [15:0] count_ff, count_in;
   logic [31:0] txt_ff, txt_in;
   logic [2:0]  txt_len_ff, txt_len_in, txt_idx_ff, txt_idx_in;
   logic [QCW-1:0] wcnt_ff, wcnt_in, rptr_ff, rptr_in;
   logic        rsp_valid_ff, rsp_valid_in, rsp_has_ff, rsp_has_in, rsp_last_ff, rsp_last_in;
   logic [7:0]  rsp_byte_ff, rsp_byte_in;
   logic [8:0]  q_mem [ut2a_pkg::QUEUE_DEPTH];
   logic [8:0]  q_rdata_ff;
   logic        emit_en, q_we;
   logic [8:0]  emit_data;

   // sequence decode
   logic [20:0] seq_cp, seq_min;
   logic        seq_valid;
   ut2a_pkg::map_res_type map_r;
   logic [ut2a_pkg::BLANK_MAX-1:0] sh;
   logic [BCW-1:0] c;
   logic [2:0]  k, nm1;
   logic [7:0]  old_blank, after_b;

   always_comb begin
      case (dcnt_ff)
         3'd2: begin
            seq_cp = {10'd0, dbytes_ff[4:0], dbytes_ff[13:8]};
            seq_min = 21'h00080;
         end
         3'd3: begin
            seq_cp = {5'd0, dbytes_ff[3:0], dbytes_ff[13:8], dbytes_ff[21:16]};
            seq_min = 21'h00800;
         end
         default: begin
            seq_cp = {dbytes_ff[2:0], dbytes_ff[13:8], dbytes_ff[21:16], dbytes_ff[29:24]};
            seq_min = 21'h10000;
         end
      endcase
      seq_valid = seq_cp >= seq_min && seq_cp < 21'h110000 &&
                  !(seq_cp >= 21'h0D800 && seq_cp <= 21'h0DFFF);
   end

   assign map_r = ut2a_pkg::map_sym(tk_cp_ff, gen_ff);
   assign old_blank = flags_ff[0] ? 8'h09 : 8'h20;

   always_comb begin
      sts.dcnt_nz = dcnt_ff != 3'd0;
      sts.is_cont = byte_ff[7:6] == 2'b10;
      sts.b_lt80 = byte_ff < 8'h80;
      sts.b_lead = byte_ff >= 8'hC0 && byte_ff <= 8'hF7;
      sts.seq_full = dcnt_ff >= ut2a_pkg::seq_len(dbytes_ff[7:0]);
      sts.seq_valid = seq_valid;
      sts.in_run = run_ff;
      sts.tk_blank = tk_is_cp_ff && (tk_cp_ff == 21'h20 || tk_cp_ff == 21'h09);
      sts.tk_emdash = tk_is_cp_ff && tk_cp_ff == ut2a_pkg::CP_EM_DASH;
      sts.dash_on = gen_ff[ut2a_pkg::GRP_DASH];
      sts.blank_nz = bcnt_ff != '0;
      sts.text_more = txt_idx_ff < txt_len_ff;
      sts.eor = eor_ff;
      sts.drain_more = rptr_ff != wcnt_ff;
      sts.rsp_done = rsp_valid_ff && rsp_ready;
   end

   always_comb begin
      gen_in = gen_ff; bbr_in = bbr_ff; bar_in = bar_ff;
      byte_in = byte_ff; eor_in = eor_ff;
      dbytes_in = dbytes_ff; dcnt_in = dcnt_ff;
      tk_is_cp_in = tk_is_cp_ff; tk_cp_in = tk_cp_ff; tk_raw_in = tk_raw_ff; tk_n_in = tk_n_ff;
      flags_in = flags_ff; bcnt_in = bcnt_ff; bbb_in = bbb_ff;
      run_in = run_ff; lead_in = lead_ff; count_in = count_ff;
      txt_in = txt_ff; txt_len_in = txt_len_ff; txt_idx_in = txt_idx_ff;
      wcnt_in = wcnt_ff; rptr_in = rptr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_byte_in = rsp_byte_ff; rsp_has_in = rsp_has_ff; rsp_last_in = rsp_last_ff;
      emit_en = 1'b0;
      emit_data = 9'd0;
      sh = flags_ff;
      c = bcnt_ff;
      k = 3'd0;
      nm1 = tk_n_ff - 3'd1;
      after_b = cmd.use_after ? bar_ff : tk_raw_ff[7:0];

      case (cmd.op)
         ut2a_pkg::OP_LATCH: begin
            byte_in = in_byte;
            eor_in = in_eor;
         end
         ut2a_pkg::OP_APPEND: begin
            dbytes_in[{dcnt_ff[1:0], 3'b000} +: 8] = byte_ff;
            dcnt_in = dcnt_ff + 3'd1;
         end
         ut2a_pkg::OP_START: begin
            dbytes_in = {24'd0, byte_ff};
            dcnt_in = 3'd1;
         end
         ut2a_pkg::OP_TK_CP_B, ut2a_pkg::OP_TK_RAW_B: begin
            tk_is_cp_in = cmd.op == ut2a_pkg::OP_TK_CP_B;
            tk_cp_in = {13'd0, byte_ff};
            tk_raw_in = {24'd0, byte_ff};
            tk_n_in = 3'd1;
         end
         ut2a_pkg::OP_TK_SEQ: begin
            tk_is_cp_in = 1'b1;
            tk_cp_in = seq_cp;
            tk_raw_in = dbytes_ff;
            tk_n_in = dcnt_ff;
            dbytes_in = 32'd0;
            dcnt_in = 3'd0;
         end
         ut2a_pkg::OP_TK_PEND: begin
            tk_is_cp_in = 1'b0;
            tk_cp_in = 21'd0;
            tk_raw_in = {24'd0, dbytes_ff[7:0]};
            tk_n_in = 3'd1;
            dbytes_in = dbytes_ff >> 8;
            dcnt_in = dcnt_ff - 3'd1;
         end
         ut2a_pkg::OP_RUN_LEAD: begin
            emit_en = lead_ff;
            emit_data = {1'b1, 8'h20};
         end
         ut2a_pkg::OP_RUN_DASH: begin
            emit_en = 1'b1;
            emit_data = {1'b1, 8'h2D};
         end
         ut2a_pkg::OP_RUN_TAIL: begin
            emit_en = !ut2a_pkg::is_edge(after_b);
            emit_data = {1'b1, 8'h20};
            run_in = 1'b0;
         end
         ut2a_pkg::OP_BLANK_PUSH: begin
            // full buffer: the oldest blank goes out and becomes the byte ahead
            if (bcnt_ff >= BCW'(ut2a_pkg::BLANK_MAX)) begin
               emit_en = 1'b1;
               emit_data = {1'b1, old_blank};
               bbb_in = old_blank;
               sh = flags_ff >> 1;
               c = bcnt_ff - BCW'(1);
            end
            sh[c[BIW-1:0]] = tk_cp_ff == 21'h09;
            flags_in = sh;
            bcnt_in = c + BCW'(1);
         end
         ut2a_pkg::OP_DASH_START: begin
            lead_in = !ut2a_pkg::is_edge(bbb_ff);
            flags_in = '0;
            bcnt_in = '0;
            run_in = 1'b1;
            if (count_ff != 16'hFFFF) count_in = count_ff + 16'd1;
         end
         ut2a_pkg::OP_FLUSH_ONE: begin
            emit_en = 1'b1;
            emit_data = {1'b1, old_blank};
            flags_in = flags_ff >> 1;
            bcnt_in = bcnt_ff - BCW'(1);
         end
         ut2a_pkg::OP_LOAD_TEXT: begin
            txt_idx_in = 3'd0;
            bbb_in = tk_raw_ff[{nm1[1:0], 3'b000} +: 8];
            if (tk_is_cp_ff && map_r.hit) begin
               txt_in = 32'd0;
               // put the first character in the low byte
               for (int i = 0; i < 4; i++) begin
                  k = map_r.len - 3'(i) - 3'd1;
                  if (3'(i) < map_r.len) txt_in[8*i +: 8] = map_r.txt[{k[1:0], 3'b000} +: 8];
               end
               txt_len_in = map_r.len;
               if (count_ff != 16'hFFFF) count_in = count_ff + 16'd1;
            end else if (tk_is_cp_ff && tk_cp_ff >= ut2a_pkg::CP_FULL_LO &&
                         tk_cp_ff <= ut2a_pkg::CP_FULL_HI && gen_ff[ut2a_pkg::GRP_FULL]) begin
               txt_in = {24'd0, 8'(tk_cp_ff - ut2a_pkg::CP_FULL_OFS)};
               txt_len_in = 3'd1;
               if (count_ff != 16'hFFFF) count_in = count_ff + 16'd1;
            end else begin
               txt_in = tk_raw_ff;
               txt_len_in = tk_n_ff;
            end
         end
         ut2a_pkg::OP_EMIT_TEXT: begin
            emit_en = 1'b1;
            emit_data = {1'b1, txt_ff[{txt_idx_ff[1:0], 3'b000} +: 8]};
            txt_idx_in = txt_idx_ff + 3'd1;
         end
         ut2a_pkg::OP_MARK: begin
            emit_en = wcnt_ff == '0;
            emit_data = 9'd0;
         end
         ut2a_pkg::OP_SHOW: begin
            rsp_valid_in = 1'b1;
            rsp_byte_in = q_rdata_ff[7:0];
            rsp_has_in = q_rdata_ff[8];
            rsp_last_in = eor_ff && (rptr_ff + QCW'(1)) == wcnt_ff;
         end
         ut2a_pkg::OP_POP: rptr_in = rptr_ff + QCW'(1);
         ut2a_pkg::OP_CLEAR: begin
            wcnt_in = '0;
            rptr_in = '0;
            if (eor_ff) begin
               dbytes_in = 32'd0;
               dcnt_in = 3'd0;
               flags_in = '0;
               bcnt_in = '0;
               bbb_in = bbr_ff;
               run_in = 1'b0;
               lead_in = 1'b0;
               count_in = 16'd0;
            end
         end
         default: ;
      endcase

      q_we = emit_en && wcnt_ff < QCW'(ut2a_pkg::QUEUE_DEPTH);
      if (q_we) wcnt_in = wcnt_ff + QCW'(1);

      if (csr_we) begin
         case (csr_index)
            ut2a_pkg::CSR_GROUP_ENABLE: gen_in = csr_data;
            ut2a_pkg::CSR_BYTE_BEFORE: begin
               bbr_in = csr_data[7:0];
               bbb_in = csr_data[7:0];
            end
            ut2a_pkg::CSR_BYTE_AFTER: bar_in = csr_data[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_ff <= ut2a_pkg::GROUP_ENABLE_RST;
         bbr_ff <= ut2a_pkg::EDGE_BYTE_RST;
         bar_ff <= ut2a_pkg::EDGE_BYTE_RST;
         bbb_ff <= ut2a_pkg::EDGE_BYTE_RST;
         eor_ff <= 1'b0;
         dbytes_ff <= 32'd0;
         dcnt_ff <= 3'd0;
         flags_ff <= '0;
         bcnt_ff <= '0;
         run_ff <= 1'b0;
         lead_ff <= 1'b0;
         count_ff <= 16'd0;
         txt_len_ff <= 3'd0;
         txt_idx_ff <= 3'd0;
         wcnt_ff <= '0;
         rptr_ff <= '0;
         rsp_valid_ff <= 1'b0;
         tk_is_cp_ff <= 1'b0;
         tk_n_ff <= 3'd1;
      end else begin
         gen_ff <= gen_in;
         bbr_ff <= bbr_in;
         bar_ff <= bar_in;
         bbb_ff <= bbb_in;
         eor_ff <= eor_in;
         dbytes_ff <= dbytes_in;
         dcnt_ff <= dcnt_in;
         flags_ff <= flags_in;
         bcnt_ff <= bcnt_in;
         run_ff <= run_in;
         lead_ff <= lead_in;
         count_ff <= count_in;
         txt_len_ff <= txt_len_in;
         txt_idx_ff <= txt_idx_in;
         wcnt_ff <= wcnt_in;
         rptr_ff <= rptr_in;
         rsp_valid_ff <= rsp_valid_in;
         tk_is_cp_ff <= tk_is_cp_in;
         tk_n_ff <= tk_n_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      tk_cp_ff <= tk_cp_in;
      tk_raw_ff <= tk_raw_in;
      txt_ff <= txt_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_has_ff <= rsp_has_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (q_we) q_mem[wcnt_ff[QAW-1:0]] <= emit_data;
   end

   always_ff @(posedge clock) begin
      if (cmd.op == ut2a_pkg::OP_RD) q_rdata_ff <= q_mem[rptr_ff[QAW-1:0]];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_byte = rsp_byte_ff;
   assign rsp_has = rsp_has_ff;
   assign rsp_last = rsp_last_ff;
   assign rsp_total = count_ff;
endmodule
`default_nettype wire

// File: rtl/core/unicode_typography_to_ascii_unit.sv
// Top level of the typography-to-ASCII unit: ports, controller and datapath.
// Depends on ut2a_pkg, ut2a_ctrl and ut2a_dpath.
//
//   channel | direction | payload
//   req_    | in        | tdata[7:0] in_byte, tlast end_of_range
//   rsp_    | out       | tdata[7:0] out_byte, [23:8] replaced_total;
//           |           | tuser has_byte, tlast last_out
//   csr_    | in        | index 0..2, data[14:0]
//
// One input word at a time: the unit takes and decodes a byte, handles each token,
// writes its bytes into the 32-entry result queue, then sends each result word out
// of the queue through a registered read and the output register, waiting while
// rsp_tready is low. req_tready is high only while idle. Reset is synchronous and
// restores the register defaults.
`default_nettype none
module unicode_typography_to_ascii_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] in_byte
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // [7:0] out_byte, [23:8] replaced_total
   output logic             rsp_tuser,   // [0] has_byte
   output logic             rsp_tlast,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [14:0] csr_data
);
   ut2a_pkg::cmd_type cmd;
   ut2a_pkg::sts_type sts;
   logic [7:0]  out_byte;
   logic [15:0] total;

   assign csr_ready = 1'b1;

   ut2a_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   ut2a_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .in_byte   (req_tdata),
      .in_eor    (req_tlast),
      .csr_we    (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_ready (rsp_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_byte  (out_byte),
      .rsp_has   (rsp_tuser),
      .rsp_last  (rsp_tlast),
      .rsp_total (total)
   );

   assign rsp_tdata = {total, out_byte};
endmodule
`default_nettype wire

// File: rtl/core/ut2a_chk.sv
// Port-level checks for the typography-to-ASCII unit, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none
module ut2a_chk (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata,
   input wire logic        rsp_tuser,
   input wire logic        rsp_tlast
);
   // hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input taken while a result is pending");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready right after an input word");

   a_marker_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast && rsp_tdata[7:0] == 8'd0)
      else $error("bare marker not final or not zero");
endmodule

bind unicode_typography_to_ascii_unit ut2a_chk u_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire
